>>> design/sm83ld_pkg.sv
// ----------------------------------------------------------------------------
// sm83ld_pkg
// Shared types, opcode names and class codes for the SM83 16-bit load unit.
// ----------------------------------------------------------------------------
package sm83ld_pkg;

    // Opcodes of the 16-bit load group
    localparam logic [7:0] OP_LD_BC    = 8'h01;
    localparam logic [7:0] OP_LD_DE    = 8'h11;
    localparam logic [7:0] OP_LD_HL    = 8'h21;
    localparam logic [7:0] OP_LD_SP    = 8'h31;
    localparam logic [7:0] OP_ST_SP    = 8'h08;
    localparam logic [7:0] OP_POP_BC   = 8'hC1;
    localparam logic [7:0] OP_POP_DE   = 8'hD1;
    localparam logic [7:0] OP_POP_HL   = 8'hE1;
    localparam logic [7:0] OP_POP_AF   = 8'hF1;
    localparam logic [7:0] OP_PUSH_BC  = 8'hC5;
    localparam logic [7:0] OP_PUSH_DE  = 8'hD5;
    localparam logic [7:0] OP_PUSH_HL  = 8'hE5;
    localparam logic [7:0] OP_PUSH_AF  = 8'hF5;
    localparam logic [7:0] OP_LD_HL_SPE = 8'hF8;
    localparam logic [7:0] OP_LD_SP_HL = 8'hF9;

    // Instruction classes produced by the decoder
    localparam logic [2:0] CLS_LD_IMM   = 3'd0;
    localparam logic [2:0] CLS_ST_SP    = 3'd1;
    localparam logic [2:0] CLS_POP      = 3'd2;
    localparam logic [2:0] CLS_PUSH     = 3'd3;
    localparam logic [2:0] CLS_LD_HL_SPE = 3'd4;
    localparam logic [2:0] CLS_LD_SP_HL = 3'd5;
    localparam logic [2:0] CLS_UNKNOWN  = 3'd6;

    // Register pair select, taken from opcode bits 5:4
    localparam logic [1:0] PAIR_BC    = 2'd0;
    localparam logic [1:0] PAIR_DE    = 2'd1;
    localparam logic [1:0] PAIR_HL    = 2'd2;
    localparam logic [1:0] PAIR_AF_SP = 2'd3;

    // Immediate bytes consumed after the opcode
    localparam logic [1:0] ADV_NONE = 2'd0;
    localparam logic [1:0] ADV_ONE  = 2'd1;
    localparam logic [1:0] ADV_TWO  = 2'd2;

    // Flag bit positions in F
    localparam int FLAG_H_BIT = 5;
    localparam int FLAG_C_BIT = 4;

    // Default depth of the queue between decoder and execute
    localparam int QUEUE_DEPTH_DEF = 2;

    // Decoded instruction word
    typedef struct packed {
        logic [2:0]  cls;
        logic [1:0]  pair;
        logic [1:0]  pc_adv;
        logic [15:0] imm;
        logic [15:0] stk;
    } item_t;

    // One result word
    typedef struct packed {
        logic        mem_write;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        last;
        logic [1:0]  pc_adv;
        logic        unk;
        logic [15:0] sp;
        logic [15:0] hl;
    } result_t;

endpackage

>>> design/sm83ld_front.sv
// ----------------------------------------------------------------------------
// sm83ld_front
// Accepts instruction words, decodes the opcode into a class and register
// pair, and holds the decoded word until the queue takes it.
// ----------------------------------------------------------------------------
module sm83ld_front
    import sm83ld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  opcode,
    input  logic [15:0] imm_word,
    input  logic [15:0] stack_word,
    output logic        push_valid,
    input  logic        push_ready,
    output item_t       push_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_dec;
    logic  accept;

    // Decode the opcode
    always_comb
    begin
        item_dec.pair   = opcode[5:4];
        item_dec.imm    = imm_word;
        item_dec.stk    = stack_word;
        item_dec.pc_adv = ADV_NONE;
        unique case (opcode) inside
            OP_LD_BC, OP_LD_DE, OP_LD_HL, OP_LD_SP:
            begin
                item_dec.cls    = CLS_LD_IMM;
                item_dec.pc_adv = ADV_TWO;
            end
            OP_ST_SP:
            begin
                item_dec.cls    = CLS_ST_SP;
                item_dec.pc_adv = ADV_TWO;
            end
            OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF:
                item_dec.cls = CLS_POP;
            OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF:
                item_dec.cls = CLS_PUSH;
            OP_LD_HL_SPE:
            begin
                item_dec.cls    = CLS_LD_HL_SPE;
                item_dec.pc_adv = ADV_ONE;
            end
            OP_LD_SP_HL:
                item_dec.cls = CLS_LD_SP_HL;
            default:
                item_dec.cls = CLS_UNKNOWN;
        endcase
    end

    // Take a new word when the stage is empty or draining into the queue
    assign in_ready   = !valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign valid_next = accept || (valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the decoded word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_dec;
        end
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

>>> design/sm83ld_queue.sv
// ----------------------------------------------------------------------------
// sm83ld_queue
// Short first-in first-out queue of decoded words between decode and execute.
// ----------------------------------------------------------------------------
module sm83ld_queue
    import sm83ld_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/sm83ld_back.sv
// ----------------------------------------------------------------------------
// sm83ld_back
// Executes decoded words against the register file and stack pointer and
// drives result words through an output register; a second write result is
// parked in a pending register and sent once the first result word is taken.
// ----------------------------------------------------------------------------
module sm83ld_back
    import sm83ld_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  item_t   pop_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic [7:0]  a_reg, f_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg;
    logic [7:0]  a_next, f_next, b_next, c_next, d_next, e_next, h_next, l_next;
    logic [15:0] sp_reg, sp_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg, pend_next;

    logic    out_load;
    logic    exec;
    logic    two_results;
    result_t first_res;
    result_t second_res;

    logic [15:0] sp_m1;
    logic [15:0] sp_m2;
    logic [15:0] sp_p2;
    logic [15:0] e8_ext;
    logic [15:0] spe_sum;
    logic [4:0]  nib_sum;
    logic [8:0]  byte_sum;
    logic [7:0]  push_hi;
    logic [7:0]  push_lo;

    assign out_load  = !out_valid_reg || out_ready;
    assign pop_ready = out_load && !pend_valid_reg;
    assign exec      = pop_valid && pop_ready;

    // Stack and offset arithmetic
    assign sp_m1    = sp_reg - 16'd1;
    assign sp_m2    = sp_reg - 16'd2;
    assign sp_p2    = sp_reg + 16'd2;
    assign e8_ext   = {{8{pop_item.imm[7]}}, pop_item.imm[7:0]};
    assign spe_sum  = sp_reg + e8_ext;
    assign nib_sum  = {1'b0, sp_reg[3:0]} + {1'b0, pop_item.imm[3:0]};
    assign byte_sum = {1'b0, sp_reg[7:0]} + {1'b0, pop_item.imm[7:0]};

    // Select the pair pushed
    always_comb
    begin
        case (pop_item.pair)
            PAIR_BC:
            begin
                push_hi = b_reg;
                push_lo = c_reg;
            end
            PAIR_DE:
            begin
                push_hi = d_reg;
                push_lo = e_reg;
            end
            PAIR_HL:
            begin
                push_hi = h_reg;
                push_lo = l_reg;
            end
            default:
            begin
                push_hi = a_reg;
                push_lo = f_reg;
            end
        endcase
    end

    // Execute the head word: next register state and its result words
    always_comb
    begin
        a_next = a_reg;
        f_next = f_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        h_next = h_reg;
        l_next = l_reg;
        sp_next = sp_reg;
        two_results = 1'b0;
        first_res  = '0;
        second_res = '0;
        first_res.last  = 1'b1;
        second_res.last = 1'b1;

        unique case (pop_item.cls)
            CLS_LD_IMM:
            begin
                case (pop_item.pair)
                    PAIR_BC:
                    begin
                        b_next = pop_item.imm[15:8];
                        c_next = pop_item.imm[7:0];
                    end
                    PAIR_DE:
                    begin
                        d_next = pop_item.imm[15:8];
                        e_next = pop_item.imm[7:0];
                    end
                    PAIR_HL:
                    begin
                        h_next = pop_item.imm[15:8];
                        l_next = pop_item.imm[7:0];
                    end
                    default:
                        sp_next = pop_item.imm;
                endcase
            end
            CLS_ST_SP:
            begin
                two_results          = 1'b1;
                first_res.mem_write  = 1'b1;
                first_res.addr       = pop_item.imm;
                first_res.data       = sp_reg[7:0];
                first_res.last       = 1'b0;
                second_res.mem_write = 1'b1;
                second_res.addr      = pop_item.imm + 16'd1;
                second_res.data      = sp_reg[15:8];
            end
            CLS_POP:
            begin
                sp_next = sp_p2;
                case (pop_item.pair)
                    PAIR_BC:
                    begin
                        b_next = pop_item.stk[15:8];
                        c_next = pop_item.stk[7:0];
                    end
                    PAIR_DE:
                    begin
                        d_next = pop_item.stk[15:8];
                        e_next = pop_item.stk[7:0];
                    end
                    PAIR_HL:
                    begin
                        h_next = pop_item.stk[15:8];
                        l_next = pop_item.stk[7:0];
                    end
                    default:
                    begin
                        // low nibble of F always reads zero
                        a_next = pop_item.stk[15:8];
                        f_next = {pop_item.stk[7:4], 4'b0000};
                    end
                endcase
            end
            CLS_PUSH:
            begin
                sp_next              = sp_m2;
                two_results          = 1'b1;
                first_res.mem_write  = 1'b1;
                first_res.addr       = sp_m1;
                first_res.data       = push_hi;
                first_res.last       = 1'b0;
                second_res.mem_write = 1'b1;
                second_res.addr      = sp_m2;
                second_res.data      = push_lo;
            end
            CLS_LD_HL_SPE:
            begin
                h_next = spe_sum[15:8];
                l_next = spe_sum[7:0];
                f_next = '0;
                f_next[FLAG_H_BIT] = nib_sum[4];
                f_next[FLAG_C_BIT] = byte_sum[8];
            end
            CLS_LD_SP_HL:
                sp_next = {h_reg, l_reg};
            default:
                first_res.unk = 1'b1;
        endcase

        // Fields shared by both result words
        first_res.pc_adv  = pop_item.pc_adv;
        second_res.pc_adv = pop_item.pc_adv;
        first_res.sp      = sp_next;
        second_res.sp     = sp_next;
        first_res.hl      = {h_next, l_next};
        second_res.hl     = {h_next, l_next};
    end

    // Steer the output and pending registers
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (out_load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else if (exec)
            begin
                out_valid_next  = 1'b1;
                out_next        = first_res;
                pend_valid_next = two_results;
                pend_next       = second_res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg          <= '0;
            f_reg          <= '0;
            b_reg          <= '0;
            c_reg          <= '0;
            d_reg          <= '0;
            e_reg          <= '0;
            h_reg          <= '0;
            l_reg          <= '0;
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                a_reg  <= a_next;
                f_reg  <= f_next;
                b_reg  <= b_next;
                c_reg  <= c_next;
                d_reg  <= d_next;
                e_reg  <= e_next;
                h_reg  <= h_next;
                l_reg  <= l_next;
                sp_reg <= sp_next;
            end
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

>>> design/sm83_sixteen_bit_load_unit.sv
// Path: decode stage register, queue, then the output register with the first result word.
// Throughput: one instruction per cycle for single-result opcodes while the output is
// not stalled; PUSH and LD (a16),SP issue two result words, one per cycle, from the output
// register. Decode stage and queue keep accepting under an output stall until full.
// Reset: A, F, B, C, D, E, H, L and SP clear to zero; queue and output registers empty.
// ----------------------------------------------------------------------------
// sm83_sixteen_bit_load_unit
// SM83 16-bit load group: decode front end, word queue and execute back end.
// ----------------------------------------------------------------------------
module sm83_sixteen_bit_load_unit
    import sm83ld_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // opcode[7:0], imm_word[23:8], stack_word[39:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // write_address[15:0], write_data[23:16],
                                       // pc_advance[25:24], sp_now[41:26],
                                       // hl_now[57:42], zero[63:58]
    output logic [1:0]  m_axis_tuser,  // mem_write[0], unknown_opcode[1]
    output logic        m_axis_tlast   // last_result
);

    logic    q_push_valid;
    logic    q_push_ready;
    item_t   q_push_item;
    logic    q_pop_valid;
    logic    q_pop_ready;
    item_t   q_pop_item;
    result_t res;

    sm83ld_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .opcode     (s_axis_tdata[7:0]),
        .imm_word   (s_axis_tdata[23:8]),
        .stack_word (s_axis_tdata[39:24]),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item)
    );

    sm83ld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    sm83ld_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (res)
    );

    // Pack the result word
    assign m_axis_tdata = {6'b000000, res.hl, res.sp, res.pc_adv, res.data, res.addr};
    assign m_axis_tuser = {res.unk, res.mem_write};
    assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
    // A result that is not a memory write is always the only one of its instruction
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("non-write result without last");

    // An unknown opcode never writes and consumes no immediate
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (!m_axis_tuser[0] && res.pc_adv == ADV_NONE))
        else $error("unknown opcode result with side effects");

    // The second write of a pair follows right after the first is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser[0] && !m_axis_tlast)
        |=> (m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast))
        else $error("second write of a pair missing");

    // The back end never pops an item while the queue is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop_ready && !q_pop_valid) |=> !(m_axis_tvalid && !$past(m_axis_tvalid)
            && !$past(q_pop_valid) && !$past(m_axis_tuser[0])))
        else $error("result appeared without a queued item");
`endif

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the SM83 16-bit load unit. A directed opening covers
// stack wrap, POP AF flag masking, signed e8 with its half and full carries
// and unknown opcodes. A long random run with random gaps on both sides
// follows. A built-in register model predicts every result word.
// ----------------------------------------------------------------------------
module tb_top;
    import sm83ld_pkg::*;

    localparam int NUM_RANDOM = 1425;

    localparam logic [7:0] GROUP_OPS [15] = '{
        OP_LD_BC, OP_LD_DE, OP_LD_HL, OP_LD_SP, OP_ST_SP,
        OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF,
        OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF,
        OP_LD_HL_SPE, OP_LD_SP_HL
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // instruction words waiting to be sent, result words still owed
    logic [39:0] instr_words_q [$];
    result_t     owed_writes_q [$];

    // register file of the model
    logic [7:0]  mdl_a, mdl_f, mdl_b, mdl_c, mdl_d, mdl_e, mdl_h, mdl_l;
    logic [15:0] mdl_sp;

    int  n_errors = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  no_idle = 1'b0;

    sm83_sixteen_bit_load_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, field, got, want);
        n_errors++;
    endtask

    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [15:0] rand_word();
        logic [15:0] corners [6];
        corners = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF};
        if ($urandom_range(0, 7) == 0)
            return corners[$urandom_range(0, 5)];
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic add_instr(input logic [7:0] op, input logic [15:0] imm,
                             input logic [15:0] stk);
        instr_words_q.push_back({stk, imm, op});
    endtask

    // Queue one owed result word; SP and HL are taken after the update
    function automatic void owe_word(input logic wr, input logic [15:0] addr,
                                     input logic [7:0] data, input logic last,
                                     input logic [1:0] adv, input logic unk);
        result_t r;
        r.mem_write = wr;
        r.addr      = addr;
        r.data      = data;
        r.last      = last;
        r.pc_adv    = adv;
        r.unk       = unk;
        r.sp        = mdl_sp;
        r.hl        = {mdl_h, mdl_l};
        owed_writes_q.push_back(r);
    endfunction

    // Execute one instruction on the register model and owe its result words
    function automatic void exec_load(input logic [39:0] word);
        logic [7:0]  op;
        logic [15:0] imm;
        logic [15:0] stk;
        logic [15:0] old_sp;
        logic [15:0] sum;
        logic [4:0]  nib_sum;
        logic [8:0]  byte_sum;
        logic [7:0]  push_hi;
        logic [7:0]  push_lo;
        op  = word[7:0];
        imm = word[23:8];
        stk = word[39:24];
        old_sp = mdl_sp;
        case (op)
            OP_LD_BC:
            begin
                {mdl_b, mdl_c} = imm;
                owe_word(1'b0, 16'h0, 8'h0, 1'b1, ADV_TWO, 1'b0);
            end
            OP_LD_DE:
            begin
                {mdl_d, mdl_e} = imm;
                owe_word(1'b0, 16'h0, 8'h0, 1'b1, ADV_TWO, 1'b0);
            end
            OP_LD_HL:
            begin
                {mdl_h, mdl_l} = imm;
                owe_word(1'b0, 16'h0, 8'h0, 1'b1, ADV_TWO, 1'b0);
            end
            OP_LD_SP:
            begin
                mdl_sp = imm;
                owe_word(1'b0, 16'h0, 8'h0, 1'b1, ADV_TWO, 1'b0);
            end
            OP_ST_SP:
            begin
                owe_word(1'b1, imm, old_sp[7:0], 1'b0, ADV_TWO, 1'b0);
                owe_word(1'b1, imm + 16'd1, old_sp[15:8], 1'b1, ADV_TWO, 1'b0);
            end
            OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF:
            begin
                case (op)
                    OP_POP_BC: {mdl_b, mdl_c} = stk;
                    OP_POP_DE: {mdl_d, mdl_e} = stk;
                    OP_POP_HL: {mdl_h, mdl_l} = stk;
                    default:
                    begin
                        // low nibble of F always reads back zero
                        mdl_a = stk[15:8];
                        mdl_f = {stk[7:4], 4'h0};
                    end
                endcase
                mdl_sp = old_sp + 16'd2;
                owe_word(1'b0, 16'h0, 8'h0, 1'b1, ADV_NONE, 1'b0);
            end
            OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF:
            begin
                case (op)
                    OP_PUSH_BC: {push_hi, push_lo} = {mdl_b, mdl_c};
                    OP_PUSH_DE: {push_hi, push_lo} = {mdl_d, mdl_e};
                    OP_PUSH_HL: {push_hi, push_lo} = {mdl_h, mdl_l};
                    default:    {push_hi, push_lo} = {mdl_a, mdl_f};
                endcase
                mdl_sp = old_sp - 16'd2;
                owe_word(1'b1, old_sp - 16'd1, push_hi, 1'b0, ADV_NONE, 1'b0);
                owe_word(1'b1, old_sp - 16'd2, push_lo, 1'b1, ADV_NONE, 1'b0);
            end
            OP_LD_HL_SPE:
            begin
                // sign-extend e8; flags come from the unsigned low-byte add
                sum      = old_sp + {{8{imm[7]}}, imm[7:0]};
                nib_sum  = {1'b0, old_sp[3:0]} + {1'b0, imm[3:0]};
                byte_sum = {1'b0, old_sp[7:0]} + {1'b0, imm[7:0]};
                mdl_f = 8'h00;
                mdl_f[FLAG_H_BIT] = nib_sum[4];
                mdl_f[FLAG_C_BIT] = byte_sum[8];
                {mdl_h, mdl_l} = sum;
                owe_word(1'b0, 16'h0, 8'h0, 1'b1, ADV_ONE, 1'b0);
            end
            OP_LD_SP_HL:
            begin
                mdl_sp = {mdl_h, mdl_l};
                owe_word(1'b0, 16'h0, 8'h0, 1'b1, ADV_NONE, 1'b0);
            end
            default:
                owe_word(1'b0, 16'h0, 8'h0, 1'b1, ADV_NONE, 1'b1);
        endcase
    endfunction

    // Driver: predict on each accepted word, then present the next after its gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            {mdl_a, mdl_f, mdl_b, mdl_c, mdl_d, mdl_e, mdl_h, mdl_l} = '0;
            mdl_sp   = '0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                exec_load(s_axis_tdata);
                if ($urandom_range(0, 39) == 0)
                    no_idle = !no_idle;
                send_gap = draw_gap();
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (instr_words_q.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= instr_words_q.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result word, then hold off for its stall
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_writes_q.size() == 0)
                begin
                    report_mismatch("unexpected result word", 32'(m_axis_tdata[15:0]), 0);
                end
                else
                begin
                    want = owed_writes_q.pop_front();
                    if (m_axis_tuser[0] !== want.mem_write)
                        report_mismatch("mem_write", 32'(m_axis_tuser[0]),
                                        32'(want.mem_write));
                    if (m_axis_tdata[15:0] !== want.addr)
                        report_mismatch("write_address", 32'(m_axis_tdata[15:0]),
                                        32'(want.addr));
                    if (m_axis_tdata[23:16] !== want.data)
                        report_mismatch("write_data", 32'(m_axis_tdata[23:16]),
                                        32'(want.data));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_result", 32'(m_axis_tlast), 32'(want.last));
                    if (m_axis_tdata[25:24] !== want.pc_adv)
                        report_mismatch("pc_advance", 32'(m_axis_tdata[25:24]),
                                        32'(want.pc_adv));
                    if (m_axis_tuser[1] !== want.unk)
                        report_mismatch("unknown_opcode", 32'(m_axis_tuser[1]),
                                        32'(want.unk));
                    if (m_axis_tdata[41:26] !== want.sp)
                        report_mismatch("sp_now", 32'(m_axis_tdata[41:26]), 32'(want.sp));
                    if (m_axis_tdata[57:42] !== want.hl)
                        report_mismatch("hl_now", 32'(m_axis_tdata[57:42]), 32'(want.hl));
                    if (m_axis_tdata[63:58] !== 6'h0)
                        report_mismatch("tdata padding", 32'(m_axis_tdata[63:58]), 0);
                end
                recv_gap = draw_gap();
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus, reset release and end of run
    initial
    begin
        logic [7:0] op;
        // directed: unknown from reset, SP wrap on PUSH, POP and LD (a16),SP
        add_instr(8'h00, 16'h0000, 16'h0000);
        add_instr(OP_LD_BC, 16'hFFFF, 16'h1234);
        add_instr(OP_LD_DE, 16'h8001, 16'hFFFF);
        add_instr(OP_LD_HL, 16'h7FFE, 16'h0000);
        add_instr(OP_LD_SP, 16'h0000, 16'hFFFF);
        add_instr(OP_PUSH_BC, 16'hFFFF, 16'h0000);
        add_instr(OP_PUSH_DE, 16'h0000, 16'h0000);
        add_instr(OP_POP_HL, 16'h0000, 16'hFFFF);
        add_instr(OP_POP_AF, 16'hFFFF, 16'h12FF);
        add_instr(OP_PUSH_AF, 16'h0000, 16'h0000);
        add_instr(OP_POP_BC, 16'h5555, 16'h0000);
        add_instr(OP_LD_SP, 16'hFFFF, 16'h0000);
        add_instr(OP_POP_DE, 16'h0000, 16'hA55A);
        add_instr(OP_ST_SP, 16'hFFFF, 16'h0000);
        // signed e8: both carries, the most negative, the most positive, -1, zero
        add_instr(OP_LD_SP, 16'h00F8, 16'h0000);
        add_instr(OP_LD_HL_SPE, 16'hAB08, 16'hFFFF);
        add_instr(OP_LD_HL_SPE, 16'h0080, 16'h0000);
        add_instr(OP_LD_HL_SPE, 16'hFF7F, 16'h0000);
        add_instr(OP_LD_SP, 16'h0000, 16'h0000);
        add_instr(OP_LD_HL_SPE, 16'h00FF, 16'h0000);
        add_instr(OP_PUSH_AF, 16'h0000, 16'h0000);
        add_instr(OP_LD_HL_SPE, 16'h0000, 16'h0000);
        add_instr(OP_PUSH_HL, 16'h0000, 16'h0000);
        add_instr(OP_LD_SP_HL, 16'hFFFF, 16'hFFFF);
        add_instr(OP_ST_SP, 16'h0000, 16'h0000);
        add_instr(8'hFF, 16'hFFFF, 16'hFFFF);
        add_instr(8'h02, 16'h8000, 16'h8000);

        // random: mostly group opcodes, some arbitrary bytes
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if ($urandom_range(0, 99) < 88)
                op = GROUP_OPS[$urandom_range(0, 14)];
            else
                op = 8'($urandom_range(0, 255));
            add_instr(op, rand_word(), rand_word());
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // drain everything, then allow the pipeline latency for stray words
        while (instr_words_q.size() != 0 || s_axis_tvalid || owed_writes_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Bound the run well beyond the slowest legal drain
    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
